>>> hdl/u8sd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
package u8sd_pkg;

    localparam int BYTE_W  = 8;
    localparam int CODE_W  = 21;
    localparam int CONT_W  = 6;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int MDATA_W = 24;

    // Byte classes that drive the automaton
    typedef enum logic [3:0] {
        CLS_ASCII    = 4'd0,   // 00..7F
        CLS_CONT_LO  = 4'd1,   // 80..8F
        CLS_LEAD2    = 4'd2,   // C2..DF
        CLS_LEAD3    = 4'd3,   // E1..EC, EE..EF
        CLS_LEAD_ED  = 4'd4,   // ED
        CLS_LEAD_F4  = 4'd5,   // F4
        CLS_LEAD4    = 4'd6,   // F1..F3
        CLS_CONT_HI  = 4'd7,   // A0..BF
        CLS_INVALID  = 4'd8,   // C0, C1, F5..FF
        CLS_CONT_MID = 4'd9,   // 90..9F
        CLS_LEAD_E0  = 4'd10,  // E0
        CLS_LEAD_F0  = 4'd11   // F0
    } byte_cls_t;

    // Automaton states, one-hot
    typedef enum logic [8:0] {
        ST_ACCEPT = 9'b000000001,
        ST_REJECT = 9'b000000010,
        ST_NEED1  = 9'b000000100,  // one continuation left
        ST_NEED2  = 9'b000001000,  // two left, any continuation
        ST_E0     = 9'b000010000,  // after E0: A0..BF only
        ST_ED     = 9'b000100000,  // after ED: 80..9F only
        ST_F0     = 9'b001000000,  // after F0: 90..BF only
        ST_NEED3  = 9'b010000000,  // three left, any continuation
        ST_F4     = 9'b100000000   // after F4: 80..8F only
    } dfa_state_t;

    // Classified item passed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        byte_cls_t         cls;
    } cls_item_t;

    // Queue status seen by the top level
    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_status_t;

    // Back-end status seen by the top level
    typedef struct packed {
        logic reject;
        logic out_full;
    } back_status_t;

endpackage

>>> hdl/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder: classifier, queue and automaton.
//
//  channel  | dir | ports                       | payload
//  ---------+-----+-----------------------------+------------------------------------
//  s_       | in  | s_tvalid s_tready s_tdata   | [7:0] in_byte
//  m_       | out | m_tvalid m_tready m_tdata   | [20:0] code_point [21] complete
//           |     |                             | [22] error [23] zero
//
//  One byte in and one result out per cycle while m_ does not stall; the automaton
//  step in the back end sets this. An accepted byte is written into the queue, and
//  the back end steps it into the result register that drives m_tvalid.
//  Synchronous active-low reset returns the automaton to accept; s_tready is low
//  during reset and until the front end's ready register is set after it. A stall
//  on m_ fills the result register and then the two-entry queue before s_tready drops.
module utf8_stream_decoder
    import u8sd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [BYTE_W-1:0]  s_tdata,   // [7:0] in_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [MDATA_W-1:0] m_tdata    // [20:0] code_point, [21] complete, [22] error
);

    logic         push;
    logic         pop;
    cls_item_t    push_item;
    cls_item_t    head_item;
    q_status_t    q_status;
    back_status_t b_status;

    u8sd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    u8sd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    u8sd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .head_item (head_item),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .b_status  (b_status)
    );

`ifndef SYNTH
    a_cmpl_err_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[21] && m_tdata[22]))
        else $error("complete and error both set");

    a_code_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[21]) |-> (m_tdata[20:0] == 21'd0))
        else $error("code point not zero on incomplete result");

    a_reject_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        b_status.reject |=> b_status.reject)
        else $error("reject state left without reset");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_status.full && !pop) |-> !push)
        else $error("push into full queue");
`endif

endmodule

>>> hdl/u8sd_front.sv
// Front end: accepts input bytes and classifies them for the automaton.
module u8sd_front
    import u8sd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    input  q_status_t         q_status,
    output logic              push,
    output cls_item_t         push_item
);

    function automatic byte_cls_t classify(input logic [BYTE_W-1:0] b);
        byte_cls_t c;
        if (b < 8'h80)       c = CLS_ASCII;
        else if (b < 8'h90)  c = CLS_CONT_LO;
        else if (b < 8'hA0)  c = CLS_CONT_MID;
        else if (b < 8'hC0)  c = CLS_CONT_HI;
        else if (b < 8'hC2)  c = CLS_INVALID;
        else if (b < 8'hE0)  c = CLS_LEAD2;
        else if (b == 8'hE0) c = CLS_LEAD_E0;
        else if (b == 8'hED) c = CLS_LEAD_ED;
        else if (b < 8'hF0)  c = CLS_LEAD3;
        else if (b == 8'hF0) c = CLS_LEAD_F0;
        else if (b < 8'hF4)  c = CLS_LEAD4;
        else if (b == 8'hF4) c = CLS_LEAD_F4;
        else                 c = CLS_INVALID;
        return c;
    endfunction

    logic ready_reg;
    logic ready_next;

    // Hold off new items while the queue is full
    always_comb begin
        ready_next = !(q_status.full) || (q_status.count != QCNT_W'(QDEPTH));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_reg <= 1'b0;
        end else begin
            ready_reg <= 1'b1;
        end
    end

    assign s_tready          = ready_reg && ready_next;
    assign push              = s_tvalid && s_tready;
    assign push_item.in_byte = s_tdata;
    assign push_item.cls     = classify(s_tdata);

endmodule

>>> hdl/u8sd_queue.sv
// Two-entry queue between the classifier and the automaton.
module u8sd_queue
    import u8sd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  cls_item_t push_item,
    input  logic      pop,
    output cls_item_t head_item,
    output q_status_t q_status
);

    cls_item_t         mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item      = mem[rd_ptr_reg];
    assign q_status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_status.empty = (count_reg == '0);
    assign q_status.count = count_reg;

endmodule

>>> hdl/u8sd_back.sv
// Back end: runs the validating automaton and holds the result register.
module u8sd_back
    import u8sd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  q_status_t          q_status,
    input  cls_item_t          head_item,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [MDATA_W-1:0] m_tdata,
    output back_status_t       b_status
);

    function automatic dfa_state_t next_state(input dfa_state_t s, input byte_cls_t c);
        dfa_state_t n;
        n = ST_REJECT;
        case (s)
            ST_ACCEPT: begin
                case (c)
                    CLS_ASCII:   n = ST_ACCEPT;
                    CLS_LEAD2:   n = ST_NEED1;
                    CLS_LEAD3:   n = ST_NEED2;
                    CLS_LEAD_E0: n = ST_E0;
                    CLS_LEAD_ED: n = ST_ED;
                    CLS_LEAD_F0: n = ST_F0;
                    CLS_LEAD4:   n = ST_NEED3;
                    CLS_LEAD_F4: n = ST_F4;
                    default:     n = ST_REJECT;
                endcase
            end
            ST_NEED1: begin
                if (c == CLS_CONT_LO || c == CLS_CONT_MID || c == CLS_CONT_HI) n = ST_ACCEPT;
            end
            ST_NEED2: begin
                if (c == CLS_CONT_LO || c == CLS_CONT_MID || c == CLS_CONT_HI) n = ST_NEED1;
            end
            ST_E0: begin
                if (c == CLS_CONT_HI) n = ST_NEED1;
            end
            ST_ED: begin
                if (c == CLS_CONT_LO || c == CLS_CONT_MID) n = ST_NEED1;
            end
            ST_F0: begin
                if (c == CLS_CONT_MID || c == CLS_CONT_HI) n = ST_NEED2;
            end
            ST_NEED3: begin
                if (c == CLS_CONT_LO || c == CLS_CONT_MID || c == CLS_CONT_HI) n = ST_NEED2;
            end
            ST_F4: begin
                if (c == CLS_CONT_LO) n = ST_NEED2;
            end
            default: n = ST_REJECT;
        endcase
        return n;
    endfunction

    dfa_state_t        state_reg, state_next;
    logic [CODE_W-1:0] partial_reg, partial_next;
    logic              out_valid_reg;
    logic [CODE_W-1:0] out_code_reg, out_code_next;
    logic              out_cmpl_reg, out_cmpl_next;
    logic              out_err_reg, out_err_next;
    logic [BYTE_W-1:0] lead_mask;

    // Advance when the output register is empty or being drained
    assign pop = !q_status.empty && (!out_valid_reg || m_tready);

    always_comb begin
        lead_mask  = 8'hFF >> head_item.cls;
        state_next = next_state(state_reg, head_item.cls);
        if (state_reg != ST_ACCEPT) begin
            partial_next = {partial_reg[CODE_W-CONT_W-1:0], head_item.in_byte[CONT_W-1:0]};
        end else begin
            partial_next = CODE_W'(lead_mask & head_item.in_byte);
        end
        out_cmpl_next = (state_next == ST_ACCEPT);
        out_err_next  = (state_next == ST_REJECT);
        out_code_next = out_cmpl_next ? partial_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_ACCEPT;
            partial_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                state_reg   <= state_next;
                partial_reg <= partial_next;
            end
            if (pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_code_reg <= out_code_next;
            out_cmpl_reg <= out_cmpl_next;
            out_err_reg  <= out_err_next;
        end
    end

    assign m_tvalid          = out_valid_reg;
    assign m_tdata           = {1'b0, out_err_reg, out_cmpl_reg, out_code_reg};
    assign b_status.reject   = (state_reg == ST_REJECT);
    assign b_status.out_full = out_valid_reg;

endmodule

>>> tb/sv/utf8_stream_decoder_test.sv
// Self-checking testbench for the UTF-8 stream decoder: random streams with a scoreboard.
module utf8_stream_decoder_test
    import u8sd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [CODE_W-1:0] code_point;
        logic              complete;
        logic              error;
    } decode_t;

    class utf8_decode_board;
        dfa_state_t        dfa;
        logic [CODE_W-1:0] partial;
        decode_t           awaited_decodes[$];
        int                bytes_seen;
        int                chars_done;
        int                results_seen;
        int                fails;

        function new();
            dfa          = ST_ACCEPT;
            partial      = '0;
            bytes_seen   = 0;
            chars_done   = 0;
            results_seen = 0;
            fails        = 0;
        endfunction

        function byte_cls_t classify(logic [BYTE_W-1:0] b);
            if (b < 8'h80) return CLS_ASCII;
            if (b < 8'h90) return CLS_CONT_LO;
            if (b < 8'hA0) return CLS_CONT_MID;
            if (b < 8'hC0) return CLS_CONT_HI;
            if (b < 8'hC2) return CLS_INVALID;
            if (b < 8'hE0) return CLS_LEAD2;
            if (b == 8'hE0) return CLS_LEAD_E0;
            if (b == 8'hED) return CLS_LEAD_ED;
            if (b < 8'hF0) return CLS_LEAD3;
            if (b == 8'hF0) return CLS_LEAD_F0;
            if (b < 8'hF4) return CLS_LEAD4;
            if (b == 8'hF4) return CLS_LEAD_F4;
            return CLS_INVALID;
        endfunction

        function dfa_state_t advance(dfa_state_t s, byte_cls_t c);
            case (s)
                ST_ACCEPT: begin
                    case (c)
                        CLS_ASCII:   return ST_ACCEPT;
                        CLS_LEAD2:   return ST_NEED1;
                        CLS_LEAD3:   return ST_NEED2;
                        CLS_LEAD_E0: return ST_E0;
                        CLS_LEAD_ED: return ST_ED;
                        CLS_LEAD_F0: return ST_F0;
                        CLS_LEAD4:   return ST_NEED3;
                        CLS_LEAD_F4: return ST_F4;
                        default:     return ST_REJECT;
                    endcase
                end
                ST_NEED1: begin
                    if (c == CLS_CONT_LO || c == CLS_CONT_MID || c == CLS_CONT_HI)
                        return ST_ACCEPT;
                end
                ST_NEED2: begin
                    if (c == CLS_CONT_LO || c == CLS_CONT_MID || c == CLS_CONT_HI)
                        return ST_NEED1;
                end
                ST_E0:    if (c == CLS_CONT_HI) return ST_NEED1;
                ST_ED:    if (c == CLS_CONT_LO || c == CLS_CONT_MID) return ST_NEED1;
                ST_F0:    if (c == CLS_CONT_MID || c == CLS_CONT_HI) return ST_NEED2;
                ST_NEED3: begin
                    if (c == CLS_CONT_LO || c == CLS_CONT_MID || c == CLS_CONT_HI)
                        return ST_NEED2;
                end
                ST_F4:    if (c == CLS_CONT_LO) return ST_NEED2;
                default:  return ST_REJECT;
            endcase
            return ST_REJECT;
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b);
            byte_cls_t  c;
            logic [7:0] lead_mask;
            decode_t    d;
            c = classify(b);
            // a lead byte keeps only its payload bits; continuation bytes add six more
            if (dfa != ST_ACCEPT) begin
                partial = {partial[CODE_W-CONT_W-1:0], b[CONT_W-1:0]};
            end else begin
                lead_mask = 8'hFF >> c;
                partial   = {{(CODE_W-BYTE_W){1'b0}}, lead_mask & b};
            end
            dfa          = advance(dfa, c);
            d.complete   = (dfa == ST_ACCEPT);
            d.error      = (dfa == ST_REJECT);
            d.code_point = d.complete ? partial : '0;
            if (d.complete) chars_done++;
            bytes_seen++;
            awaited_decodes.push_back(d);
        endfunction

        function void check_result(logic [MDATA_W-1:0] data);
            decode_t want;
            results_seen++;
            if (awaited_decodes.size() == 0) begin
                $error("result 0x%06h arrived with no byte outstanding", data);
                fails++;
                return;
            end
            want = awaited_decodes.pop_front();
            if (data[CODE_W-1:0] !== want.code_point) begin
                $error("code_point: expected 0x%06h, got 0x%06h",
                       want.code_point, data[CODE_W-1:0]);
                fails++;
            end
            if (data[CODE_W] !== want.complete) begin
                $error("complete: expected %0b, got %0b", want.complete, data[CODE_W]);
                fails++;
            end
            if (data[CODE_W+1] !== want.error) begin
                $error("error: expected %0b, got %0b", want.error, data[CODE_W+1]);
                fails++;
            end
            if (data[MDATA_W-1:CODE_W+2] !== '0) begin
                $error("pad: expected 0, got %0b", data[MDATA_W-1:CODE_W+2]);
                fails++;
            end
        endfunction

        function void check_drained();
            if (awaited_decodes.size() != 0) begin
                $error("%0d results never arrived", awaited_decodes.size());
                fails++;
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [BYTE_W-1:0]  s_tdata;    // [7:0] in_byte
    logic               m_tvalid;
    logic               m_tready;
    logic [MDATA_W-1:0] m_tdata;    // [20:0] code_point, [21] complete, [22] error, [23] zero

    utf8_decode_board board = new();
    int               src_idle;
    int               sink_stall;
    int               hold_len;
    int               idle_count;
    int               clean_bytes;

    utf8_stream_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // note accepted bytes first, then check results, all on pre-edge values
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) board.note_byte(s_tdata);
            if (m_tvalid && m_tready) board.check_result(m_tdata);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_count <= 0;
        end else if (idle_count >= STALL_LIMIT) begin
            $error("no item moved for %0d cycles", STALL_LIMIT);
            $display("utf8_stream_decoder: mismatch");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    // receiver: random stalls, plus a long hold-off when requested
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_len != 0) begin
                m_tready <= 1'b0;
                repeat (hold_len) @(negedge aclk);
                hold_len = 0;
            end
            m_tready <= ($urandom_range(0, 99) >= sink_stall);
        end
    end

    // entered and left at a falling edge
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_char(input logic [CODE_W-1:0] cp);
        if (cp < 21'h80) begin
            send_byte({1'b0, cp[6:0]});
        end else if (cp < 21'h800) begin
            send_byte({3'b110, cp[10:6]});
            send_byte({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            send_byte({4'b1110, cp[15:12]});
            send_byte({2'b10, cp[11:6]});
            send_byte({2'b10, cp[5:0]});
        end else begin
            send_byte({5'b11110, cp[20:18]});
            send_byte({2'b10, cp[17:12]});
            send_byte({2'b10, cp[11:6]});
            send_byte({2'b10, cp[5:0]});
        end
    endtask

    function automatic logic [CODE_W-1:0] pick_char();
        int          len;
        int          pick;
        int unsigned lo;
        int unsigned hi;
        int unsigned cp;
        len  = $urandom_range(1, 4);
        pick = $urandom_range(0, 9);
        case (len)
            1:       begin lo = 0;        hi = 'h7F;     end
            2:       begin lo = 'h80;     hi = 'h7FF;    end
            3:       begin lo = 'h800;    hi = 'hFFFF;   end
            default: begin lo = 'h10000;  hi = 'h10FFFF; end
        endcase
        if (pick == 0) cp = lo;
        else if (pick == 1) cp = hi;
        else if (len == 3 && pick == 2) cp = 'hD7FF;
        else if (len == 3 && pick == 3) cp = 'hE000;
        else cp = $urandom_range(hi, lo);
        // steer away from the surrogate block
        if (cp >= 'hD800 && cp <= 'hDFFF) cp = cp ^ 'h1000;
        return cp[CODE_W-1:0];
    endfunction

    task automatic run_phase(input int src_pct, input int sink_pct, input int nbytes,
                             input bit squeeze);
        int stop_at;
        src_idle   = src_pct;
        sink_stall = sink_pct;
        stop_at    = board.bytes_seen + nbytes;
        if (squeeze) hold_len = 80;
        while (board.bytes_seen < stop_at) send_char(pick_char());
    endtask

    // one malformed sequence drives the decoder into its sticky reject state
    task automatic send_broken();
        case ($urandom_range(0, 5))
            0: begin
                send_byte(BYTE_W'($urandom_range(8'hC1, 8'hC0)));
                send_byte(BYTE_W'($urandom_range(8'hBF, 8'h80)));
            end
            1: begin
                send_byte(8'hE0);
                send_byte(BYTE_W'($urandom_range(8'h9F, 8'h80)));
            end
            2: begin
                send_byte(8'hED);
                send_byte(BYTE_W'($urandom_range(8'hBF, 8'hA0)));
            end
            3: begin
                send_byte(8'hF4);
                send_byte(BYTE_W'($urandom_range(8'hBF, 8'h90)));
            end
            4: send_byte(BYTE_W'($urandom_range(8'hBF, 8'h80)));
            default: begin
                send_byte(BYTE_W'($urandom_range(8'hEF, 8'hE1)));
                send_byte(BYTE_W'($urandom_range(8'h7F, 8'h00)));
            end
        endcase
    endtask

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        src_idle   = 0;
        sink_stall = 0;
        hold_len   = 0;
        idle_count = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // boundary characters of every sequence length
        send_char(21'h000000);
        send_char(21'h00007F);
        send_char(21'h000080);
        send_char(21'h0007FF);
        send_char(21'h000800);
        send_char(21'h00D7FF);
        send_char(21'h00FFFF);
        send_char(21'h010000);
        send_char(21'h10FFFF);

        run_phase(0, 0, 150, 1'b1);
        run_phase(48, 0, 150, 1'b0);
        run_phase(0, 48, 150, 1'b0);
        run_phase(30, 30, 150, 1'b0);
        clean_bytes = board.bytes_seen;

        // malformed input, then noise while rejected
        src_idle   = 30;
        sink_stall = 30;
        send_broken();
        repeat (50) send_byte(BYTE_W'($urandom_range(8'hFF, 8'h00)));
        s_tvalid <= 1'b0;

        while (board.awaited_decodes.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        board.check_drained();

        $display("checked %0d results for %0d bytes: %0d characters decoded,",
                 board.results_seen, board.bytes_seen, board.chars_done);
        $display("%0d well-formed bytes before one malformed sequence and a rejected tail",
                 clean_bytes);
        if (board.fails == 0) begin
            $display("utf8_stream_decoder: match");
        end else begin
            $display("utf8_stream_decoder: mismatch");
        end
        $finish;
    end

endmodule
